// ===== rtl/sfcrc_pkg.sv =====
// Package for the sensor frame CRC builder and checker.
// Holds frame constants, the queue entry type and the CRC-16/MODBUS byte update.
`default_nettype none

package sfcrc_pkg;

   localparam int unsigned FRAME_BYTES = 24;
   localparam int unsigned POS_W       = 5;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;
   localparam int unsigned QCNT_W      = 3;

   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY     = 16'hA001;
   localparam logic [31:0] HEADER_RESET = 32'hC8D7B6A5;

   localparam logic [POS_W-1:0] POS_OP       = POS_W'(4);
   localparam logic [POS_W-1:0] POS_ARG1     = POS_W'(5);
   localparam logic [POS_W-1:0] POS_ARG2     = POS_W'(6);
   localparam logic [POS_W-1:0] POS_STATUS   = POS_W'(7);
   localparam logic [POS_W-1:0] POS_HIGH     = POS_W'(10);
   localparam logic [POS_W-1:0] POS_LOW      = POS_W'(11);
   localparam logic [POS_W-1:0] POS_CRC_LO   = POS_W'(FRAME_BYTES - 2);
   localparam logic [POS_W-1:0] POS_LAST     = POS_W'(FRAME_BYTES - 1);

   localparam logic CMD_SEND    = 1'b0;
   localparam logic CMD_RECEIVE = 1'b1;
   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef struct packed {
      logic       verdict;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic       ok;
   } sfcrc_entry_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sfcrc_req_if.sv =====
// Request channel interface: valid/ready handshake with the input item fields.
// Standalone; no package dependency.
`default_nettype none

interface sfcrc_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] op_code;
   logic [7:0] arg_first;
   logic [7:0] arg_second;
   logic [7:0] reply_byte;

   modport source (output valid, output cmd, output op_code, output arg_first,
                   output arg_second, output reply_byte, input ready);
   modport sink   (input valid, input cmd, input op_code, input arg_first,
                   input arg_second, input reply_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/sfcrc_rsp_if.sv =====
// Response channel interface: valid/ready handshake with the result item fields.
// Standalone; no package dependency.
`default_nettype none

interface sfcrc_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] frame_byte;
   logic       last;
   logic       crc_ok;
   logic [7:0] reply_status;
   logic [7:0] reply_high;
   logic [7:0] reply_low;

   modport source (output valid, output kind, output frame_byte, output last,
                   output crc_ok, output reply_status, output reply_high,
                   output reply_low, input ready);
   modport sink   (input valid, input kind, input frame_byte, input last,
                   input crc_ok, input reply_status, input reply_high,
                   input reply_low, output ready);
endinterface

`default_nettype wire

// ===== rtl/sfcrc_front.sv =====
// Front part: accepts request items, tracks the reply frame and its CRC,
// and pushes send jobs and verdicts into the queue. Uses sfcrc_pkg and sfcrc_req_if.
`default_nettype none

module sfcrc_front
   import sfcrc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   sfcrc_req_if.sink      req_ch,
   input  wire logic      q_full,
   output sfcrc_entry_type push_entry,
   output logic           push
);

   logic [POS_W-1:0] reply_count_ff, reply_count_in;
   logic [15:0]      reply_crc_ff, reply_crc_in;
   logic [7:0]       crc_low_ff, crc_low_in;
   logic [7:0]       status_ff, status_in;
   logic [7:0]       high_ff, high_in;
   logic [7:0]       low_ff, low_in;
   logic             accept;
   logic             end_of_reply;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && !q_full;
   assign end_of_reply = reply_count_ff >= POS_LAST;

   always_comb begin
      reply_count_in = reply_count_ff;
      reply_crc_in   = reply_crc_ff;
      crc_low_in     = crc_low_ff;
      status_in      = status_ff;
      high_in        = high_ff;
      low_in         = low_ff;
      push           = 1'b0;
      push_entry     = '{verdict: KIND_BYTE, b0: req_ch.op_code, b1: req_ch.arg_first,
                         b2: req_ch.arg_second, ok: 1'b0};
      if (accept) begin
         if (req_ch.cmd == CMD_SEND) begin
            push = 1'b1;
         end else begin
            if (reply_count_ff >= POS_OP && reply_count_ff < POS_CRC_LO) begin
               reply_crc_in = crc_byte(reply_crc_ff, req_ch.reply_byte);
            end
            if (reply_count_ff == POS_STATUS) begin
               status_in = req_ch.reply_byte;
            end
            if (reply_count_ff == POS_HIGH) begin
               high_in = req_ch.reply_byte;
            end
            if (reply_count_ff == POS_LOW) begin
               low_in = req_ch.reply_byte;
            end
            if (reply_count_ff == POS_CRC_LO) begin
               crc_low_in = req_ch.reply_byte;
            end
            if (end_of_reply) begin
               push           = 1'b1;
               push_entry     = '{verdict: KIND_VERDICT, b0: status_ff, b1: high_ff,
                                  b2: low_ff,
                                  ok: ({req_ch.reply_byte, crc_low_ff} == reply_crc_ff)};
               reply_count_in = '0;
               reply_crc_in   = CRC_INIT;
            end else begin
               reply_count_in = reply_count_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reply_count_ff <= '0;
         reply_crc_ff   <= CRC_INIT;
         crc_low_ff     <= '0;
         status_ff      <= '0;
         high_ff        <= '0;
         low_ff         <= '0;
      end else begin
         reply_count_ff <= reply_count_in;
         reply_crc_ff   <= reply_crc_in;
         crc_low_ff     <= crc_low_in;
         status_ff      <= status_in;
         high_ff        <= high_in;
         low_ff         <= low_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      reply_count_ff <= POS_LAST)
      else $error("reply position beyond frame end");

   a_verdict_restarts: assert property (@(posedge clock) disable iff (reset)
      push && push_entry.verdict |=> reply_count_ff == '0 && reply_crc_ff == CRC_INIT)
      else $error("reply state not restarted after verdict");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push)
      else $error("push into full queue");

endmodule

`default_nettype wire

// ===== rtl/sfcrc_queue.sv =====
// Short job queue between the front and back parts.
// Uses sfcrc_pkg for the entry type and depth.
`default_nettype none

module sfcrc_queue
   import sfcrc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire sfcrc_entry_type push_entry,
   input  wire logic            pop,
   output sfcrc_entry_type      head,
   output logic                 empty,
   output logic                 full
);

   sfcrc_entry_type   slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign empty = count_ff == '0;
   assign full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count overflow");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== rtl/sfcrc_back.sv =====
// Back part: takes jobs from the queue, serializes send frames with their CRC
// and presents verdicts, through a registered response stage. Uses sfcrc_pkg and sfcrc_rsp_if.
`default_nettype none

module sfcrc_back
   import sfcrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [31:0] header,
   input  wire sfcrc_entry_type head,
   input  wire logic        empty,
   output logic             pop,
   sfcrc_rsp_if.source      rsp_ch
);

   logic             busy_ff, busy_in;
   logic [POS_W-1:0] idx_ff, idx_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       op_ff, op_in;
   logic [7:0]       a1_ff, a1_in;
   logic [7:0]       a2_ff, a2_in;

   logic             valid_ff, valid_in;
   logic             kind_ff, kind_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             ok_ff, ok_in;
   logic [7:0]       st_ff, st_in;
   logic [7:0]       hi_ff, hi_in;
   logic [7:0]       lo_ff, lo_in;

   logic             load_ok;
   logic [7:0]       cur_byte;

   assign load_ok = !valid_ff || rsp_ch.ready;

   always_comb begin
      case (idx_ff)
         POS_W'(0): cur_byte = header[31:24];
         POS_W'(1): cur_byte = header[23:16];
         POS_W'(2): cur_byte = header[15:8];
         POS_W'(3): cur_byte = header[7:0];
         POS_OP:    cur_byte = op_ff;
         POS_ARG1:  cur_byte = a1_ff;
         POS_ARG2:  cur_byte = a2_ff;
         POS_CRC_LO: cur_byte = crc_ff[7:0];
         POS_LAST:  cur_byte = crc_ff[15:8];
         default:   cur_byte = 8'h00;
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      crc_in   = crc_ff;
      op_in    = op_ff;
      a1_in    = a1_ff;
      a2_in    = a2_ff;
      valid_in = valid_ff && !rsp_ch.ready;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      ok_in    = ok_ff;
      st_in    = st_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      pop      = 1'b0;
      if (load_ok) begin
         if (busy_ff) begin
            valid_in = 1'b1;
            kind_in  = KIND_BYTE;
            byte_in  = cur_byte;
            last_in  = idx_ff == POS_LAST;
            ok_in    = 1'b0;
            st_in    = '0;
            hi_in    = '0;
            lo_in    = '0;
            if (idx_ff >= POS_OP && idx_ff < POS_CRC_LO) begin
               crc_in = crc_byte(crc_ff, cur_byte);
            end
            if (idx_ff == POS_LAST) begin
               busy_in = 1'b0;
            end
            idx_in = idx_ff + POS_W'(1);
         end else if (!empty) begin
            pop      = 1'b1;
            valid_in = 1'b1;
            if (head.verdict == KIND_VERDICT) begin
               kind_in = KIND_VERDICT;
               byte_in = '0;
               last_in = 1'b1;
               ok_in   = head.ok;
               st_in   = head.b0;
               hi_in   = head.b1;
               lo_in   = head.b2;
            end else begin
               kind_in = KIND_BYTE;
               byte_in = header[31:24];
               last_in = 1'b0;
               ok_in   = 1'b0;
               st_in   = '0;
               hi_in   = '0;
               lo_in   = '0;
               busy_in = 1'b1;
               idx_in  = POS_W'(1);
               crc_in  = CRC_INIT;
               op_in   = head.b0;
               a1_in   = head.b1;
               a2_in   = head.b2;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff  <= crc_in;
      op_ff   <= op_in;
      a1_ff   <= a1_in;
      a2_ff   <= a2_in;
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      ok_ff   <= ok_in;
      st_ff   <= st_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.kind         = kind_ff;
   assign rsp_ch.frame_byte   = byte_ff;
   assign rsp_ch.last         = last_ff;
   assign rsp_ch.crc_ok       = ok_ff;
   assign rsp_ch.reply_status = st_ff;
   assign rsp_ch.reply_high   = hi_ff;
   assign rsp_ch.reply_low    = lo_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff != '0 && idx_ff <= POS_LAST)
      else $error("frame byte index out of range while busy");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !pop)
      else $error("queue popped during frame serialization");

   a_verdict_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff == KIND_VERDICT |-> last_ff)
      else $error("verdict without last");

endmodule

`default_nettype wire

// ===== rtl/sensor_frame_crc_builder_checker.sv =====
// Top level of the sensor frame CRC builder and checker.
// An item is taken each cycle while the queue has room; a verdict is queued, then registered.
// A send item yields 24 bytes, one per cycle while the response side is ready.
// The back part's serializer takes no new job from the queue until the current frame is done.
// A four-entry queue lets the front keep accepting items while a frame is serialized.
// Synchronous reset restores the header 0xC8D7B6A5, the reply count and CRC, and empties all stages.
`default_nettype none

module sensor_frame_crc_builder_checker
   import sfcrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   sfcrc_req_if.sink        req_ch,
   sfcrc_rsp_if.source      rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata
);

   logic [31:0]     header_ff;
   sfcrc_entry_type push_entry;
   sfcrc_entry_type head;
   logic            push;
   logic            pop;
   logic            q_empty;
   logic            q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
      end else if (csr_we) begin
         header_ff <= csr_wdata;
      end
   end

   sfcrc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .q_full     (q_full),
      .push_entry (push_entry),
      .push       (push)
   );

   sfcrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (q_empty),
      .full       (q_full)
   );

   sfcrc_back u_back (
      .clock  (clock),
      .reset  (reset),
      .header (header_ff),
      .head   (head),
      .empty  (q_empty),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the sensor frame CRC builder and checker: drives command and reply items,
// predicts every transmit byte and verdict in a scoreboard class, and compares them in order.
// Depends on sfcrc_pkg and the sfcrc_req_if / sfcrc_rsp_if channel interfaces.
`timescale 1ns / 1ps

module tb_top;
   import sfcrc_pkg::*;

   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASE_ITEMS  = 36;

   typedef struct packed {
      logic       kind;
      logic [7:0] frame_byte;
      logic       last;
      logic       crc_ok;
      logic [7:0] status;
      logic [7:0] high;
      logic [7:0] low;
   } frame_result_type;

   class frame_scoreboard;
      logic [31:0]      header;
      logic [4:0]       reply_count;
      logic [15:0]      reply_crc;
      logic [7:0]       crc_low_byte;
      logic [7:0]       saved_status;
      logic [7:0]       saved_high;
      logic [7:0]       saved_low;
      frame_result_type pending_results[$];
      int               errors;
      int               verdicts;
      int               good_verdicts;

      function new();
         header        = HEADER_RESET;
         reply_count   = '0;
         reply_crc     = CRC_INIT;
         crc_low_byte  = '0;
         saved_status  = '0;
         saved_high    = '0;
         saved_low     = '0;
         errors        = 0;
         verdicts      = 0;
         good_verdicts = 0;
      endfunction

      static function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] data);
         logic [15:0] c;
         logic        fb;
         c = crc;
         for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ data[i];
            c  = {1'b0, c[15:1]};
            if (fb) begin
               c = c ^ CRC_POLY;
            end
         end
         return c;
      endfunction

      function void set_header(logic [31:0] value);
         header = value;
      endfunction

      function void take_item(logic cmd, logic [7:0] op, logic [7:0] a1, logic [7:0] a2,
                              logic [7:0] rb);
         logic [7:0]       bytes [FRAME_BYTES];
         logic [15:0]      crc;
         frame_result_type r;
         if (cmd == CMD_SEND) begin
            foreach (bytes[i]) bytes[i] = 8'h00;
            {bytes[0], bytes[1], bytes[2], bytes[3]} = header;
            bytes[4] = op;
            bytes[5] = a1;
            bytes[6] = a2;
            crc = CRC_INIT;
            for (int i = 4; i < FRAME_BYTES - 2; i++) begin
               crc = crc_update(crc, bytes[i]);
            end
            bytes[FRAME_BYTES-2] = crc[7:0];
            bytes[FRAME_BYTES-1] = crc[15:8];
            for (int i = 0; i < FRAME_BYTES; i++) begin
               r            = '0;
               r.kind       = KIND_BYTE;
               r.frame_byte = bytes[i];
               r.last       = (i == FRAME_BYTES - 1);
               pending_results.push_back(r);
            end
         end else begin
            if (reply_count >= POS_OP && reply_count < POS_CRC_LO) begin
               reply_crc = crc_update(reply_crc, rb);
            end
            if (reply_count == POS_STATUS) saved_status = rb;
            if (reply_count == POS_HIGH) saved_high = rb;
            if (reply_count == POS_LOW) saved_low = rb;
            if (reply_count == POS_CRC_LO) crc_low_byte = rb;
            if (reply_count >= POS_LAST) begin
               r        = '0;
               r.kind   = KIND_VERDICT;
               r.last   = 1'b1;
               r.crc_ok = ({rb, crc_low_byte} == reply_crc);
               r.status = saved_status;
               r.high   = saved_high;
               r.low    = saved_low;
               pending_results.push_back(r);
               reply_count = '0;
               reply_crc   = CRC_INIT;
            end else begin
               reply_count = reply_count + 5'd1;
            end
         end
      endfunction

      function void compare_field(string name, int unsigned exp, int unsigned act);
         if (exp != act) begin
            errors++;
            $display("%0t: mismatch on %s, expected 0x%0h, actual 0x%0h", $time, name, exp, act);
         end
      endfunction

      function void check_result(frame_result_type got);
         frame_result_type exp;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result item, expected none, actual 0x%0h", $time, got);
            return;
         end
         exp = pending_results.pop_front();
         compare_field("kind", exp.kind, got.kind);
         compare_field("frame_byte", exp.frame_byte, got.frame_byte);
         compare_field("last", exp.last, got.last);
         compare_field("crc_ok", exp.crc_ok, got.crc_ok);
         compare_field("reply_status", exp.status, got.status);
         compare_field("reply_high", exp.high, got.high);
         compare_field("reply_low", exp.low, got.low);
         if (got.kind == KIND_VERDICT) begin
            verdicts++;
            if (got.crc_ok) good_verdicts++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we;
   logic [31:0] csr_wdata;

   sfcrc_req_if req_if();
   sfcrc_rsp_if rsp_if();

   sensor_frame_crc_builder_checker dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   frame_scoreboard model;
   bit              steady [2];
   bit              stall_request = 1'b0;
   int              n_items    = 0;
   int              n_sends    = 0;
   int              n_replies  = 0;
   int              n_headers  = 1;
   int              n_holds    = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int draw_gap(int side);
      if ($urandom_range(0, 15) == 0) steady[side] = ~steady[side];
      if (steady[side]) return 0;
      return $urandom_range(0, 14);
   endfunction

   function automatic logic [7:0] rnd8();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic push_item(input int gap, input logic cmd, input logic [7:0] op,
                            input logic [7:0] a1, input logic [7:0] a2, input logic [7:0] rb);
      logic got;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.cmd        <= cmd;
      req_if.op_code    <= op;
      req_if.arg_first  <= a1;
      req_if.arg_second <= a2;
      req_if.reply_byte <= rb;
      got = 1'b0;
      while (!got) begin
         @(negedge clock);
         got = req_if.ready;
         @(posedge clock);
      end
      model.take_item(cmd, op, a1, a2, rb);
      n_items++;
      if (cmd == CMD_SEND) n_sends++;
      else n_replies++;
   endtask

   task automatic push_random_send(input int gap);
      push_item(gap, CMD_SEND, rnd8(), rnd8(), rnd8(), rnd8());
   endtask

   task automatic push_reply_frame(input bit corrupt, input int send_at, input bit extreme);
      logic [7:0]  bytes [FRAME_BYTES];
      logic [15:0] crc;
      int          pos;
      int          bit_at;
      foreach (bytes[i]) bytes[i] = extreme ? {8{i[0]}} : rnd8();
      crc = CRC_INIT;
      for (int i = 4; i < FRAME_BYTES - 2; i++) begin
         crc = frame_scoreboard::crc_update(crc, bytes[i]);
      end
      bytes[FRAME_BYTES-2] = crc[7:0];
      bytes[FRAME_BYTES-1] = crc[15:8];
      if (corrupt) begin
         pos    = $urandom_range(4, FRAME_BYTES - 1);
         bit_at = $urandom_range(0, 7);
         bytes[pos][bit_at] = ~bytes[pos][bit_at];
      end
      for (int i = 0; i < FRAME_BYTES; i++) begin
         if (i == send_at) push_random_send(draw_gap(0));
         push_item(draw_gap(0), CMD_RECEIVE, rnd8(), rnd8(), rnd8(), bytes[i]);
      end
   endtask

   task automatic run_random_phase(input int target);
      int start;
      int pick;
      start = n_items;
      while (n_items - start < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            push_random_send(draw_gap(0));
         end else if (pick < 85) begin
            while (model.reply_count != 0) begin
               push_item(draw_gap(0), CMD_RECEIVE, rnd8(), rnd8(), rnd8(), rnd8());
            end
            push_reply_frame($urandom_range(0, 3) == 0,
                             ($urandom_range(0, 5) == 0) ? $urandom_range(0, 23) : -1, 1'b0);
         end else begin
            repeat ($urandom_range(1, 4)) begin
               push_item(draw_gap(0), 1'($urandom_range(0, 1)), rnd8(), rnd8(), rnd8(), rnd8());
            end
         end
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (model.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_header(input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      model.set_header(value);
      n_headers++;
   endtask

   initial begin
      int               gap;
      logic             seen;
      frame_result_type r;
      rsp_if.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (stall_request) begin
            stall_request = 1'b0;
            gap = HOLD_CYCLES;
            n_holds++;
         end else begin
            gap = draw_gap(1);
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         seen = 1'b0;
         while (!seen) begin
            @(negedge clock);
            seen         = rsp_if.valid;
            r.kind       = rsp_if.kind;
            r.frame_byte = rsp_if.frame_byte;
            r.last       = rsp_if.last;
            r.crc_ok     = rsp_if.crc_ok;
            r.status     = rsp_if.reply_status;
            r.high       = rsp_if.reply_high;
            r.low        = rsp_if.reply_low;
            @(posedge clock);
         end
         model.check_result(r);
      end
   end

   initial begin
      logic [31:0] headers [5];
      model = new();
      req_if.valid      <= 1'b0;
      req_if.cmd        <= CMD_SEND;
      req_if.op_code    <= 8'h00;
      req_if.arg_first  <= 8'h00;
      req_if.arg_second <= 8'h00;
      req_if.reply_byte <= 8'h00;
      csr_we            <= 1'b0;
      csr_wdata         <= 32'h0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      push_item(0, CMD_SEND, 8'h00, 8'h00, 8'h00, 8'h00);
      push_item(draw_gap(0), CMD_SEND, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      push_reply_frame(1'b0, 10, 1'b1);
      drain();

      headers[0] = 32'h0000_0000;
      headers[1] = 32'hFFFF_FFFF;
      headers[2] = $urandom;
      headers[3] = $urandom;
      headers[4] = HEADER_RESET;
      for (int p = 0; p < 5; p++) begin
         write_header(headers[p]);
         if (p == 1) begin
            stall_request = 1'b1;
            repeat (10) push_random_send(0);
         end
         run_random_phase(PHASE_ITEMS);
         drain();
      end

      $display("Ran %0d command frames and %0d reply bytes under %0d header settings.",
               n_sends, n_replies, n_headers);
      $display("Checked %0d verdicts (%0d with a matching CRC) and %0d long output hold(s).",
               model.verdicts, model.good_verdicts, n_holds);
      if (model.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
